/* hw/rtl/ise_pkg.sv */
// Package for the insertion sort engine: sizes, payload structs and sequencer codes.
// Used by insertion_sort_engine and by the testbench; depends on nothing.
`default_nettype none
package ise_pkg;

   localparam int MAX_ITEMS = 64;
   localparam int IDX_W     = $clog2(MAX_ITEMS);
   localparam int CNT_W     = IDX_W + 1;
   localparam int VALUE_W   = 32;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] sorted_value;
      logic                      end_of_run;
   } rsp_type;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_KEY_RD   = 3'd1;
   localparam logic [2:0] ST_KEY_CAP  = 3'd2;
   localparam logic [2:0] ST_CMP_RD   = 3'd3;
   localparam logic [2:0] ST_CMP      = 3'd4;
   localparam logic [2:0] ST_EMIT_RD  = 3'd5;
   localparam logic [2:0] ST_EMIT     = 3'd6;

endpackage
`default_nettype wire

/* hw/rtl/ise_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used by insertion_sort_engine for the element store.
`default_nettype none
module ise_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

/* hw/rtl/insertion_sort_engine.sv */
// Top level of the insertion sort engine: load sequencer, sort sequencer, output register.
// Depends on ise_pkg and ise_ram.
`default_nettype none
// Values stream in one transaction per cycle while req_stall is low and are stored until
// a transaction with last set arrives; values beyond MAX_ITEMS are dropped silently. The
// stored set is then sorted in place by a stable insertion sort (ascending when
// csr_write_data last wrote 1, the reset choice) and emitted with end_of_run on the final
// element. While sorting and emitting, req_stall is high. The store has one read and one
// write port with a registered read, so each key fetch passes ST_KEY_RD and ST_KEY_CAP,
// each compare-and-shift step passes ST_CMP_RD and ST_CMP, and each element is emitted
// through ST_EMIT_RD and ST_EMIT.
module insertion_sort_engine
   import ise_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload,
   input  wire logic    csr_write_enable,
   input  wire logic    csr_write_data
);

   logic [2:0]               state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         i_ff, i_in;
   logic [IDX_W-1:0]         j_ff, j_in;
   logic [IDX_W-1:0]         k_ff, k_in;
   logic signed [VALUE_W-1:0] key_ff, key_in;
   logic                     ascending_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic [VALUE_W-1:0]       wr_data;
   logic [IDX_W-1:0]         rd_addr;
   logic [VALUE_W-1:0]       rd_data;
   logic signed [VALUE_W-1:0] prev;
   logic                     out_of_order;
   logic                     req_accept;
   logic                     rsp_free;
   logic                     key_done;
   logic                     emit_last;
   logic [CNT_W-1:0]         stored;

   ise_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAX_ITEMS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign prev        = signed'(rd_data);
   // The single compare unit; strict compares keep equal values in arrival order.
   assign out_of_order = ascending_ff ? (prev > key_ff) : (prev < key_ff);
   assign key_done    = ({1'b0, i_ff} + CNT_W'(1)) == count_ff;
   assign emit_last   = ({1'b0, k_ff} + CNT_W'(1)) == count_ff;
   assign stored      = (count_ff < CNT_W'(MAX_ITEMS)) ? count_ff + CNT_W'(1) : count_ff;

   always_comb begin
      unique case (state_ff)
         ST_KEY_RD:              rd_addr = i_ff;
         ST_CMP_RD:              rd_addr = j_ff - IDX_W'(1);
         ST_EMIT_RD, ST_EMIT:    rd_addr = k_ff;
         default:                rd_addr = '0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      key_in       = key_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      wr_addr      = count_ff[IDX_W-1:0];
      wr_data      = req_payload.value;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (count_ff < CNT_W'(MAX_ITEMS)) begin
                  wr_en = 1'b1;
               end
               count_in = stored;
               if (req_payload.last) begin
                  i_in = IDX_W'(1);
                  k_in = '0;
                  state_in = (stored == CNT_W'(1)) ? ST_EMIT_RD : ST_KEY_RD;
               end
            end
         end
         ST_KEY_RD: begin
            state_in = ST_KEY_CAP;
         end
         ST_KEY_CAP: begin
            key_in   = signed'(rd_data);
            j_in     = i_ff;
            state_in = ST_CMP_RD;
         end
         ST_CMP_RD: begin
            if (j_ff == '0) begin
               // The key is the new head of the sorted prefix.
               wr_en    = 1'b1;
               wr_addr  = '0;
               wr_data  = key_ff;
               i_in     = i_ff + IDX_W'(1);
               state_in = key_done ? ST_EMIT_RD : ST_KEY_RD;
            end else begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            wr_en   = 1'b1;
            wr_addr = j_ff;
            if (out_of_order) begin
               wr_data  = prev;
               j_in     = j_ff - IDX_W'(1);
               state_in = ST_CMP_RD;
            end else begin
               wr_data  = key_ff;
               i_in     = i_ff + IDX_W'(1);
               state_in = key_done ? ST_EMIT_RD : ST_KEY_RD;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.sorted_value = signed'(rd_data);
               rsp_in.end_of_run   = emit_last;
               if (emit_last) begin
                  count_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + IDX_W'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ascending_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            ascending_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff   <= i_in;
      j_ff   <= j_in;
      k_ff   <= k_in;
      key_ff <= key_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ITEMS))
      else $error("element count exceeds capacity");

   a_busy_nonempty : assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (count_ff != '0))
      else $error("sequencer busy with an empty store");

   a_cmp_index : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> ((j_ff != '0) && (j_ff <= i_ff)))
      else $error("compare position outside the sorted prefix");

   a_run_end : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EMIT) && rsp_free && emit_last)
         |=> ((state_ff == ST_IDLE) && (count_ff == '0) && rsp_valid_ff
              && rsp_ff.end_of_run))
      else $error("run end did not empty the store");

endmodule
`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for insertion_sort_engine: directed sets, then random sets in phases.
// Depends on ise_pkg and the engine RTL; a sort mirror predicts all runs but the typed ones.
module tb;
   import ise_pkg::*;

   localparam int QUIET_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 16;
   localparam int PHASE_ITEMS   = 75;
   localparam int LONG_HOLD     = 5000;

   localparam bit DIR_UP      = 1'b1;
   localparam bit DIR_DOWN    = 1'b0;
   localparam bit CHECK_TYPED = 1'b1;
   localparam bit CHECK_MODEL = 1'b0;

   localparam int PAT_RANDOM  = 0;
   localparam int PAT_RISING  = 1;
   localparam int PAT_FALLING = 2;
   localparam int PAT_FLAT    = 3;

   localparam logic signed [VALUE_W-1:0] V_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] V_MAX = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
      logic                      up;
      logic                      typed;
      logic signed [VALUE_W-1:0] want;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 24;
   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      // Single-element runs at the extremes and around zero read straight off the definition.
      {V_MIN,    1'b1, DIR_UP,   CHECK_TYPED, V_MIN},
      {V_MAX,    1'b1, DIR_UP,   CHECK_TYPED, V_MAX},
      {32'sd0,   1'b1, DIR_UP,   CHECK_TYPED, 32'sd0},
      {-32'sd1,  1'b1, DIR_UP,   CHECK_TYPED, -32'sd1},
      // Duplicates and both extremes in one ascending set.
      {32'sd7,   1'b0, DIR_UP,   CHECK_MODEL, 32'sd0},
      {-32'sd3,  1'b0, DIR_UP,   CHECK_MODEL, 32'sd0},
      {32'sd7,   1'b0, DIR_UP,   CHECK_MODEL, 32'sd0},
      {V_MAX,    1'b0, DIR_UP,   CHECK_MODEL, 32'sd0},
      {V_MIN,    1'b0, DIR_UP,   CHECK_MODEL, 32'sd0},
      {32'sd0,   1'b1, DIR_UP,   CHECK_MODEL, 32'sd0},
      {V_MAX,    1'b1, DIR_DOWN, CHECK_TYPED, V_MAX},
      {V_MIN,    1'b0, DIR_DOWN, CHECK_MODEL, 32'sd0},
      {-32'sd1,  1'b0, DIR_DOWN, CHECK_MODEL, 32'sd0},
      {V_MAX,    1'b0, DIR_DOWN, CHECK_MODEL, 32'sd0},
      {-32'sd1,  1'b0, DIR_DOWN, CHECK_MODEL, 32'sd0},
      {32'sd1,   1'b1, DIR_DOWN, CHECK_MODEL, 32'sd0},
      // Already in order for descending, then fully reversed for ascending.
      {32'sd4,   1'b0, DIR_DOWN, CHECK_MODEL, 32'sd0},
      {32'sd3,   1'b0, DIR_DOWN, CHECK_MODEL, 32'sd0},
      {32'sd2,   1'b0, DIR_DOWN, CHECK_MODEL, 32'sd0},
      {32'sd1,   1'b1, DIR_DOWN, CHECK_MODEL, 32'sd0},
      {32'sd4,   1'b0, DIR_UP,   CHECK_MODEL, 32'sd0},
      {32'sd3,   1'b0, DIR_UP,   CHECK_MODEL, 32'sd0},
      {32'sd2,   1'b0, DIR_UP,   CHECK_MODEL, 32'sd0},
      {32'sd1,   1'b1, DIR_UP,   CHECK_MODEL, 32'sd0}
   };

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;
   logic    csr_write_enable;
   logic    csr_write_data;

   // Mirror of the engine's store and direction register.
   logic signed [VALUE_W-1:0] mirror_store [MAX_ITEMS];
   int unsigned               mirror_count;
   bit                        mirror_up;
   rsp_type                   fresh_run [$];
   rsp_type                   pending_sorted [$];

   int          failures;
   int unsigned quiet_cycles = 0;
   int          send_idle_pct;
   int          stall_pct;
   int          long_hold;
   int          phase_id;

   insertion_sort_engine i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Appends one value and, on the last one, leaves the stably sorted run in fresh_run.
   function automatic void load_and_sort(req_type item);
      logic signed [VALUE_W-1:0] key;
      int unsigned               i;
      int unsigned               j;
      rsp_type                   r;
      fresh_run.delete();
      if (mirror_count < MAX_ITEMS) begin
         mirror_store[mirror_count] = item.value;
         mirror_count++;
      end
      if (item.last) begin
         for (i = 1; i < mirror_count; i++) begin
            key = mirror_store[i];
            j = i;
            while (j > 0 && (mirror_up ? (mirror_store[j-1] > key)
                                       : (mirror_store[j-1] < key))) begin
               mirror_store[j] = mirror_store[j-1];
               j--;
            end
            mirror_store[j] = key;
         end
         for (i = 0; i < mirror_count; i++) begin
            r.sorted_value = mirror_store[i];
            r.end_of_run   = (i == mirror_count - 1);
            fresh_run.push_back(r);
         end
         mirror_count = 0;
      end
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom;
         4, 5, 6:    return $urandom_range(0, 16) - 8;
         7:          return $urandom_range(0, 1) ? V_MAX : V_MIN;
         default:    return $urandom_range(0, 1) ? V_MAX - $urandom_range(0, 3)
                                                 : V_MIN + $urandom_range(0, 3);
      endcase
   endfunction

   // Entered and left at a falling edge.
   task automatic send_item(input req_type item, input bit typed,
                            input logic signed [VALUE_W-1:0] want);
      rsp_type r;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      load_and_sort(item);
      if (typed) begin
         if (item.last) begin
            r.sorted_value = want;
            r.end_of_run   = 1'b1;
            pending_sorted.push_back(r);
         end
      end else begin
         foreach (fresh_run[k]) pending_sorted.push_back(fresh_run[k]);
      end
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_sorted.size() != 0) @(negedge clock);
   endtask

   task automatic settle();
      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_direction(input bit up);
      csr_write_enable <= 1'b1;
      csr_write_data   <= up;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      mirror_up = up;
      @(negedge clock);
   endtask

   task automatic send_set(input int n, input int pattern);
      req_type                   item;
      logic signed [VALUE_W-1:0] base;
      int                        k;
      base = pick_value();
      for (k = 0; k < n; k++) begin
         case (pattern)
            PAT_RISING:  item.value = base + k;
            PAT_FALLING: item.value = base - k;
            PAT_FLAT:    item.value = base;
            default:     item.value = pick_value();
         endcase
         item.last = (k == n - 1);
         send_item(item, CHECK_MODEL, 32'sd0);
      end
   endtask

   task automatic run_phase(input int idle_pct, input int stall_p, input int hold,
                            input bit up, input int big_set);
      int sent;
      int n;
      settle();
      set_direction(up);
      send_idle_pct = idle_pct;
      stall_pct <= stall_p;
      long_hold <= hold;
      phase_id  <= phase_id + 1;
      sent = 0;
      // The large set runs against the sort direction, the slowest case.
      if (big_set > 0) begin
         send_set(big_set, up ? PAT_FALLING : PAT_RISING);
         sent = big_set;
      end
      while (sent < PHASE_ITEMS) begin
         if ($urandom_range(0, 9) == 0) drain();
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         send_set(n, $urandom_range(PAT_RANDOM, PAT_FLAT));
         sent += n;
      end
   endtask

   initial begin : stimulus
      req_type item;
      int      r;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_payload      = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = 1'b0;
      failures         = 0;
      mirror_count     = 0;
      mirror_up        = DIR_UP;
      send_idle_pct    = 0;
      stall_pct        = 0;
      long_hold        = 0;
      phase_id         = 0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      set_direction(DIR_UP);

      for (r = 0; r < DIRECTED_ROWS; r++) begin
         if (DIRECTED[r].up != mirror_up) begin
            settle();
            set_direction(DIRECTED[r].up);
         end
         item.value = DIRECTED[r].value;
         item.last  = DIRECTED[r].last;
         send_item(item, DIRECTED[r].typed, DIRECTED[r].want);
      end

      run_phase(0, 0, 0, DIR_DOWN, 0);
      run_phase(45, 0, 0, DIR_UP, 0);
      run_phase(0, 45, 0, DIR_DOWN, 0);
      // Receiver holds off while an overfull set streams in and sorts; the tail is dropped.
      run_phase(10, 10, LONG_HOLD, $urandom_range(0, 1), MAX_ITEMS + $urandom_range(1, 5));
      run_phase(0, 0, 0, DIR_UP, MAX_ITEMS);

      settle();
      if (pending_sorted.size() != 0) begin
         $error("%0d sorted results never arrived", pending_sorted.size());
         failures++;
      end
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin : receiver
      int unsigned hold_left;
      int          seen_phase;
      hold_left  = 0;
      seen_phase = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (phase_id != seen_phase) begin
            seen_phase = phase_id;
            hold_left  = long_hold;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_sorted.size() == 0) begin
            $error("unexpected result: sorted_value %0d end_of_run %0b",
                   rsp_payload.sorted_value, rsp_payload.end_of_run);
            failures++;
         end else begin
            want = pending_sorted.pop_front();
            if (rsp_payload.sorted_value !== want.sorted_value) begin
               $error("sorted_value: expected %0d, got %0d",
                      want.sorted_value, rsp_payload.sorted_value);
               failures++;
            end
            if (rsp_payload.end_of_run !== want.end_of_run) begin
               $error("end_of_run: expected %0b, got %0b",
                      want.end_of_run, rsp_payload.end_of_run);
               failures++;
            end
         end
      end
   end

   // Long sorts accept nothing on either side, so the limit covers a full reversed store.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (!reset && rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

/* files.f */
hw/rtl/ise_pkg.sv
hw/rtl/ise_ram.sv
hw/rtl/insertion_sort_engine.sv
test/tb.sv
